@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the integer multiply-add unit.
// Bodies compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define IMAU_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
// Check a property on every clock edge, reset included.
`define IMAU_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define IMAU_ASSERT(label, clk, rstn, prop)
`define IMAU_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ hw/rtl/imau_pkg.sv @@
// Package of the integer multiply-add unit: operation codes, control struct
// and helper functions. No dependencies.
package imau_pkg;

    localparam logic [1:0] CMD_MUL      = 2'd0;
    localparam logic [1:0] CMD_MAD      = 2'd1;
    localparam logic [1:0] CMD_MUL24    = 2'd2;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    localparam logic [1:0] HALF_LO       = 2'd0;
    localparam logic [1:0] HALF_HI       = 2'd1;
    localparam logic [1:0] HALF_WIDE     = 2'd2;
    localparam logic [1:0] HALF_RESERVED = 2'd3;

    localparam logic [31:0] INT32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] INT32_MIN = 32'h8000_0000;

    typedef struct packed {
        logic       bad;
        logic [1:0] cmd;
        logic [1:0] size;
        logic [1:0] half;
        logic       sat;
        logic       sgn;
    } ctl_t;

    // Mask of the low 8, 16, 32 or 64 bits.
    function automatic logic [63:0] width_mask(input logic [1:0] size);
        logic [63:0] m;
        unique case (size)
            SIZE_8:  m = 64'h0000_0000_0000_00FF;
            SIZE_16: m = 64'h0000_0000_0000_FFFF;
            SIZE_32: m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    // Sign- or zero-extend the operand from its width (24 bits for mul24).
    function automatic logic [63:0] extend_op(input logic [63:0] v, input logic [1:0] size,
                                              input logic is24, input logic sgn);
        logic [63:0] r;
        if (is24) begin
            r = {{40{sgn & v[23]}}, v[23:0]};
        end else begin
            unique case (size)
                SIZE_8:  r = {{56{sgn & v[7]}}, v[7:0]};
                SIZE_16: r = {{48{sgn & v[15]}}, v[15:0]};
                SIZE_32: r = {{32{sgn & v[31]}}, v[31:0]};
                default: r = v;
            endcase
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/integer_multiply_add_unit.sv @@
// Integer multiply / multiply-add unit, five register stages deep; uses imau_pkg.
// Path: an item passes the dec, pp, acc, sel and fin registers in turn, and m_tvalid
// rises when it reaches fin. Throughput: one item per cycle, as every
// stage takes a new transfer whenever the stage after it advances or is empty.
// Stalls: each stage holds while the stage after it is full and stalled.
// Reset (aresetn low, synchronous) clears all valid bits; payload is not reset.
`include "assert_macros.svh"
module integer_multiply_add_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // src_a [63:0], src_b [127:64], src_c [191:128]
    input  logic [191:0] s_tdata,
    // cmd [1:0], size_code [3:2], signed_ops [4], half_mode [6:5], saturate [7]
    input  logic [7:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result [63:0]
    output logic [63:0]  m_tdata,
    // invalid [0]
    output logic         m_tuser
);

    // Stage handshakes: each stage takes a transfer when empty or draining.
    logic           dec_valid, pp_valid, acc_valid, sel_valid;
    logic           pp_ready, acc_ready, sel_ready, fin_ready;
    imau_pkg::ctl_t dec_ctl, pp_ctl, acc_ctl, sel_ctl;

    // Decode stage outputs: extended operands.
    logic [63:0] dec_a, dec_b, dec_c;
    // Partial products.
    logic [63:0] pp_ll, pp_lh, pp_hl, pp_hh, pp_corr, pp_c;
    // Accumulated words.
    logic [63:0] acc_plo, acc_hpre, acc_c;
    logic [1:0]  acc_carry;
    // Selected part of the product.
    logic [63:0] sel_x, sel_c;

    imau_dec u_dec (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .cmd        (s_tuser[1:0]),
        .size_code  (s_tuser[3:2]),
        .signed_ops (s_tuser[4]),
        .half_mode  (s_tuser[6:5]),
        .saturate   (s_tuser[7]),
        .src_a      (s_tdata[63:0]),
        .src_b      (s_tdata[127:64]),
        .src_c      (s_tdata[191:128]),
        .out_valid  (dec_valid),
        .out_ready  (pp_ready),
        .out_ctl    (dec_ctl),
        .out_a      (dec_a),
        .out_b      (dec_b),
        .out_c      (dec_c)
    );

    imau_pp u_pp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (pp_ready),
        .in_ctl    (dec_ctl),
        .in_a      (dec_a),
        .in_b      (dec_b),
        .in_c      (dec_c),
        .out_valid (pp_valid),
        .out_ready (acc_ready),
        .out_ctl   (pp_ctl),
        .out_ll    (pp_ll),
        .out_lh    (pp_lh),
        .out_hl    (pp_hl),
        .out_hh    (pp_hh),
        .out_corr  (pp_corr),
        .out_c     (pp_c)
    );

    imau_acc u_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pp_valid),
        .in_ready  (acc_ready),
        .in_ctl    (pp_ctl),
        .in_ll     (pp_ll),
        .in_lh     (pp_lh),
        .in_hl     (pp_hl),
        .in_hh     (pp_hh),
        .in_corr   (pp_corr),
        .in_c      (pp_c),
        .out_valid (acc_valid),
        .out_ready (sel_ready),
        .out_ctl   (acc_ctl),
        .out_plo   (acc_plo),
        .out_hpre  (acc_hpre),
        .out_carry (acc_carry),
        .out_c     (acc_c)
    );

    imau_sel u_sel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (acc_valid),
        .in_ready  (sel_ready),
        .in_ctl    (acc_ctl),
        .in_plo    (acc_plo),
        .in_hpre   (acc_hpre),
        .in_carry  (acc_carry),
        .in_c      (acc_c),
        .out_valid (sel_valid),
        .out_ready (fin_ready),
        .out_ctl   (sel_ctl),
        .out_x     (sel_x),
        .out_c     (sel_c)
    );

    // Output register: a finished result waits here while earlier stages advance.
    imau_fin u_fin (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (sel_valid),
        .in_ready    (fin_ready),
        .in_ctl      (sel_ctl),
        .in_x        (sel_x),
        .in_c        (sel_c),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (m_tdata),
        .out_invalid (m_tuser)
    );

    // An unsupported combination always carries a zero result.
    `IMAU_ASSERT(a_invalid_zero, aclk, aresetn, (m_tvalid && m_tuser) |-> (m_tdata == 64'd0))
    // The input side only stalls when a result is waiting at a stalled output.
    `IMAU_ASSERT(a_stall_source, aclk, aresetn, !s_tready |-> (m_tvalid && !m_tready))
    // Reset empties the pipeline.
    `IMAU_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

endmodule

@@ hw/rtl/imau_dec.sv @@
// Decode stage of the integer multiply-add unit: validity check, operand
// extension and input register. Depends on imau_pkg.
module imau_dec (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [1:0]         size_code,
    input  logic               signed_ops,
    input  logic [1:0]         half_mode,
    input  logic               saturate,
    input  logic [63:0]        src_a,
    input  logic [63:0]        src_b,
    input  logic [63:0]        src_c,
    output logic               out_valid,
    input  logic               out_ready,
    output imau_pkg::ctl_t     out_ctl,
    output logic [63:0]        out_a,
    output logic [63:0]        out_b,
    output logic [63:0]        out_c
);

    logic           valid_reg;
    imau_pkg::ctl_t ctl_reg;
    imau_pkg::ctl_t ctl_next;
    logic [63:0]    a_reg, b_reg, c_reg;
    logic           is24;
    logic           bad;

    assign is24 = (cmd == imau_pkg::CMD_MUL24);

    always_comb begin
        bad = 1'b0;
        if (cmd == imau_pkg::CMD_RESERVED || half_mode == imau_pkg::HALF_RESERVED) begin
            bad = 1'b1;
        end else if (is24) begin
            bad = (size_code != imau_pkg::SIZE_32) || (half_mode == imau_pkg::HALF_WIDE);
        end else begin
            bad = (half_mode == imau_pkg::HALF_WIDE) && (size_code == imau_pkg::SIZE_64);
        end
        ctl_next.bad  = bad;
        ctl_next.cmd  = cmd;
        ctl_next.size = size_code;
        ctl_next.half = half_mode;
        ctl_next.sat  = saturate;
        ctl_next.sgn  = signed_ops;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            ctl_reg <= ctl_next;
            a_reg   <= imau_pkg::extend_op(src_a, size_code, is24, signed_ops);
            b_reg   <= imau_pkg::extend_op(src_b, size_code, is24, signed_ops);
            // c only feeds a multiply-add
            c_reg   <= (cmd == imau_pkg::CMD_MAD)
                       ? imau_pkg::extend_op(src_c, size_code, 1'b0, signed_ops) : 64'd0;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;
    assign out_c     = c_reg;

endmodule

@@ hw/rtl/imau_pp.sv @@
// Partial product stage: four 32x32 unsigned multipliers and the signed
// correction term of the 64-bit high half. Depends on imau_pkg.
module imau_pp (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  imau_pkg::ctl_t     in_ctl,
    input  logic [63:0]        in_a,
    input  logic [63:0]        in_b,
    input  logic [63:0]        in_c,
    output logic               out_valid,
    input  logic               out_ready,
    output imau_pkg::ctl_t     out_ctl,
    output logic [63:0]        out_ll,
    output logic [63:0]        out_lh,
    output logic [63:0]        out_hl,
    output logic [63:0]        out_hh,
    output logic [63:0]        out_corr,
    output logic [63:0]        out_c
);

    logic           valid_reg;
    imau_pkg::ctl_t ctl_reg;
    logic [63:0]    ll_reg, lh_reg, hl_reg, hh_reg, corr_reg, c_reg;
    logic [63:0]    corr_next;

    // Two's complement high half: subtract b when a is negative, a when b is.
    assign corr_next = ((in_ctl.sgn && in_a[63]) ? in_b : 64'd0)
                     + ((in_ctl.sgn && in_b[63]) ? in_a : 64'd0);

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            ctl_reg  <= in_ctl;
            ll_reg   <= in_a[31:0]  * in_b[31:0];
            lh_reg   <= in_a[31:0]  * in_b[63:32];
            hl_reg   <= in_a[63:32] * in_b[31:0];
            hh_reg   <= in_a[63:32] * in_b[63:32];
            corr_reg <= corr_next;
            c_reg    <= in_c;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_ll    = ll_reg;
    assign out_lh    = lh_reg;
    assign out_hl    = hl_reg;
    assign out_hh    = hh_reg;
    assign out_corr  = corr_reg;
    assign out_c     = c_reg;

endmodule

@@ hw/rtl/imau_acc.sv @@
// Accumulate stage: combine partial products into the low word, a pre-sum of
// the high word and the carry between them. Depends on imau_pkg.
module imau_acc (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  imau_pkg::ctl_t     in_ctl,
    input  logic [63:0]        in_ll,
    input  logic [63:0]        in_lh,
    input  logic [63:0]        in_hl,
    input  logic [63:0]        in_hh,
    input  logic [63:0]        in_corr,
    input  logic [63:0]        in_c,
    output logic               out_valid,
    input  logic               out_ready,
    output imau_pkg::ctl_t     out_ctl,
    output logic [63:0]        out_plo,
    output logic [63:0]        out_hpre,
    output logic [1:0]         out_carry,
    output logic [63:0]        out_c
);

    logic           valid_reg;
    imau_pkg::ctl_t ctl_reg;
    logic [63:0]    plo_reg, hpre_reg, c_reg;
    logic [1:0]     carry_reg;
    logic [33:0]    mid;
    logic [63:0]    hpre_next;

    assign mid = {2'b00, in_ll[63:32]} + {2'b00, in_lh[31:0]} + {2'b00, in_hl[31:0]};
    assign hpre_next = in_hh + {32'd0, in_lh[63:32]} + {32'd0, in_hl[63:32]} - in_corr;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            ctl_reg   <= in_ctl;
            plo_reg   <= {mid[31:0], in_ll[31:0]};
            hpre_reg  <= hpre_next;
            carry_reg <= mid[33:32];
            c_reg     <= in_c;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_plo   = plo_reg;
    assign out_hpre  = hpre_reg;
    assign out_carry = carry_reg;
    assign out_c     = c_reg;

endmodule

@@ hw/rtl/imau_sel.sv @@
// Select stage: finish the high word and pick the product part that the
// result is built from. Depends on imau_pkg.
module imau_sel (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  imau_pkg::ctl_t     in_ctl,
    input  logic [63:0]        in_plo,
    input  logic [63:0]        in_hpre,
    input  logic [1:0]         in_carry,
    input  logic [63:0]        in_c,
    output logic               out_valid,
    input  logic               out_ready,
    output imau_pkg::ctl_t     out_ctl,
    output logic [63:0]        out_x,
    output logic [63:0]        out_c
);

    logic           valid_reg;
    imau_pkg::ctl_t ctl_reg;
    logic [63:0]    x_reg, c_reg;
    logic [63:0]    phi;
    logic [63:0]    x_next;

    assign phi = in_hpre + {62'd0, in_carry};

    always_comb begin
        x_next = in_plo;
        if (in_ctl.cmd == imau_pkg::CMD_MUL24) begin
            // 24-bit high form returns product bits 47..16
            if (in_ctl.half == imau_pkg::HALF_HI) begin
                x_next = {16'd0, in_plo[63:16]};
            end
        end else if (in_ctl.half == imau_pkg::HALF_HI) begin
            unique case (in_ctl.size)
                imau_pkg::SIZE_8:  x_next = {8'd0, in_plo[63:8]};
                imau_pkg::SIZE_16: x_next = {16'd0, in_plo[63:16]};
                imau_pkg::SIZE_32: x_next = {32'd0, in_plo[63:32]};
                default:           x_next = phi;
            endcase
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            ctl_reg <= in_ctl;
            x_reg   <= x_next;
            c_reg   <= in_c;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_x     = x_reg;
    assign out_c     = c_reg;

endmodule

@@ hw/rtl/imau_fin.sv @@
// Final stage: add c, mask to the result width, saturate, zero an invalid
// result, and hold the result in the output register. Depends on imau_pkg.
module imau_fin (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  imau_pkg::ctl_t     in_ctl,
    input  logic [63:0]        in_x,
    input  logic [63:0]        in_c,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [63:0]        out_result,
    output logic               out_invalid
);

    logic        valid_reg;
    logic [63:0] result_reg, result_next;
    logic        invalid_reg;
    logic [63:0] sum;
    logic [32:0] ssum;
    logic [63:0] mask;
    logic        sat_case;

    assign sum  = in_x + in_c;
    assign ssum = {in_x[31], in_x[31:0]} + {in_c[31], in_c[31:0]};
    assign sat_case = (in_ctl.cmd == imau_pkg::CMD_MAD) && (in_ctl.half == imau_pkg::HALF_HI)
                   && in_ctl.sat && in_ctl.sgn && (in_ctl.size == imau_pkg::SIZE_32);

    always_comb begin
        if (in_ctl.cmd == imau_pkg::CMD_MUL24) begin
            mask = imau_pkg::width_mask(imau_pkg::SIZE_32);
        end else if (in_ctl.half == imau_pkg::HALF_WIDE) begin
            // wide at 64 bits is flagged bad and zeroed, so size + 1 only counts in range
            mask = imau_pkg::width_mask(in_ctl.size + 2'd1);
        end else begin
            mask = imau_pkg::width_mask(in_ctl.size);
        end
        priority if (in_ctl.bad) begin
            result_next = 64'd0;
        end else if (sat_case && (ssum[32] != ssum[31])) begin
            result_next = {32'd0, ssum[32] ? imau_pkg::INT32_MIN : imau_pkg::INT32_MAX};
        end else begin
            result_next = sum & mask;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            result_reg  <= result_next;
            invalid_reg <= in_ctl.bad;
        end
    end

    assign out_valid   = valid_reg;
    assign out_result  = result_reg;
    assign out_invalid = invalid_reg;

endmodule
